FILE: hdl/cprgd_pkg.sv
package cprgd_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 24;
	localparam int CPR_W = 17;
	localparam int NL_EDGES = 58;
	localparam int DIV_BPS = 8;

	// NL zone boundaries in units of 1e-8 degree, ascending
	localparam logic [33:0] NL_EDGE [NL_EDGES] = '{
		34'd1047047130, 34'd1482817437, 34'd1818626357, 34'd2102939493,
		34'd2354504487, 34'd2582924707, 34'd2793898710, 34'd2991135686,
		34'd3177209708, 34'd3353993436, 34'd3522899598, 34'd3685025108,
		34'd3841241892, 34'd3992256684, 34'd4138651832, 34'd4280914012,
		34'd4419454951, 34'd4554626723, 34'd4686733252, 34'd4816039128,
		34'd4942776439, 34'd5067150166, 34'd5189342469, 34'd5309516153,
		34'd5427817472, 34'd5544378444, 34'd5659318756, 34'd5772747354,
		34'd5884763776, 34'd5995459277, 34'd6104917774, 34'd6213216659,
		34'd6320427479, 34'd6426616523, 34'd6531845310, 34'd6636171008,
		34'd6739646774, 34'd6842322022, 34'd6944242631, 34'd7045451075,
		34'd7145986473, 34'd7245884545, 34'd7345177442, 34'd7443893416,
		34'd7542056257, 34'd7639684391, 34'd7736789461, 34'd7833374083,
		34'd7929428225, 34'd8024923213, 34'd8119801349, 34'd8213956981,
		34'd8307199445, 34'd8399173563, 34'd8489166191, 34'd8575541621,
		34'd8653536998, 34'd8700000000
	};

	// smallest fixed-point |lat| that has reached boundary idx
	function automatic logic [63:0] nl_thr(input int idx, input int frac);
		return ((64'(NL_EDGE[idx]) << frac) + 64'd99999999) / 64'd100000000;
	endfunction

endpackage

FILE: hdl/cprgd_div_pipe.sv
module cprgd_div_pipe #(
	parameter int NW = 16,
	parameter int DW = 6,
	parameter int PW = 1,
	parameter int BPS = cprgd_pkg::DIV_BPS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NW-1:0] out_quot,
	output logic [DW-1:0] out_rem,
	output logic [PW-1:0] out_pay
);
	localparam int ST = (NW + BPS - 1) / BPS;

	logic [NW-1:0] num_sk  [ST];
	logic [NW-1:0] quot_sk [ST];
	logic [DW-1:0] rem_sk  [ST];
	logic [DW-1:0] den_sk  [ST];
	logic [PW-1:0] pay_sk  [ST];
	logic [ST-1:0] vld_sk;
	logic [ST-1:0] rdy;
	logic [NW-1:0] num_nx  [ST];
	logic [NW-1:0] quot_nx [ST];
	logic [DW-1:0] rem_nx  [ST];
	logic [ST-1:0] vin;

	// hold a stage while the one after it is full and stalled
	always_comb begin
		rdy[ST-1] = !vld_sk[ST-1] || out_ready;
		for (int s = ST - 2; s >= 0; s--) begin
			rdy[s] = !vld_sk[s] || rdy[s+1];
		end
	end

	// restoring division, BPS quotient bits per stage
	always_comb begin
		logic [NW-1:0] n;
		logic [NW-1:0] q;
		logic [DW-1:0] r;
		logic [DW-1:0] d;
		logic [DW:0]   r2;
		for (int s = 0; s < ST; s++) begin
			if (s == 0) begin
				n = in_num;
				q = '0;
				r = '0;
				d = in_den;
				vin[s] = in_valid;
			end else begin
				n = num_sk[s-1];
				q = quot_sk[s-1];
				r = rem_sk[s-1];
				d = den_sk[s-1];
				vin[s] = vld_sk[s-1];
			end
			for (int i = 0; i < BPS; i++) begin
				if (s * BPS + i < NW) begin
					r2 = {r, n[NW-1]};
					n = {n[NW-2:0], 1'b0};
					if (r2 >= {1'b0, d}) begin
						r2 = r2 - {1'b0, d};
						q = {q[NW-2:0], 1'b1};
					end else begin
						q = {q[NW-2:0], 1'b0};
					end
					r = r2[DW-1:0];
				end
			end
			num_nx[s] = n;
			quot_nx[s] = q;
			rem_nx[s] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= '0;
		end else begin
			for (int s = 0; s < ST; s++) begin
				if (rdy[s]) begin
					vld_sk[s] <= vin[s];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < ST; s++) begin
			if (rdy[s] && vin[s]) begin
				num_sk[s] <= num_nx[s];
				quot_sk[s] <= quot_nx[s];
				rem_sk[s] <= rem_nx[s];
				den_sk[s] <= (s == 0) ? in_den : den_sk[s-1];
				pay_sk[s] <= (s == 0) ? in_pay : pay_sk[s-1];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_sk[ST-1];
	assign out_quot  = quot_sk[ST-1];
	assign out_rem   = rem_sk[ST-1];
	assign out_pay   = pay_sk[ST-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sk[ST-1] |-> rem_sk[ST-1] < den_sk[ST-1])
		else $error("remainder not below divisor");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sk[0] |-> den_sk[0] != '0)
		else $error("zero divisor entered divider");
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_sk)
		else $error("divider refused a word with a free stage");

endmodule

FILE: hdl/cpr_global_position_decode_top.sv
// CPR global airborne position decode, fully pipelined.
// Input stream s_axis: one word holds a matched even/odd frame pair; tdata
// carries the four 17-bit CPR fields, tuser flags the odd frame as newer.
// Output stream m_axis: one word per input word, in order; tuser is the
// fix flag, tdata the latitude and longitude in signed Q.ANGLE_FRAC_BITS
// degrees (both zero when the pair is rejected for NL mismatch or poles).
// Throughput: one word per cycle, with no bubbles while m_axis_tready stays
// high. The pipeline has 10 + ceil(12/8) + ceil((F+16)/8) register stages,
// F = ANGLE_FRAC_BITS: ten plain stages (the odd latitude scale by 1/59
// takes three of them, as two reciprocal multiplies) and the two restoring
// dividers (longitude zone modulo, longitude scale by the zone count),
// eight bits a stage.
// A stall on m_axis_tready holds every full stage; ready ripples back so
// that s_axis_tready falls only once all stages are full. Nothing is lost
// or repeated. Reset (arst_n low) empties the pipeline at once; there is no
// other state and no clearing pass.
module cpr_global_position_decode_top #(
	parameter int ANGLE_FRAC_BITS = cprgd_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// even_lat_cpr[16:0], even_lon_cpr[33:17], odd_lat_cpr[50:34],
	// odd_lon_cpr[67:51], zero fill [71:68]
	input  logic [71:0] s_axis_tdata,
	// odd_newer
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// lat_deg[31:0], lon_deg[64:32], zero fill [71:65]
	output logic [71:0] m_axis_tdata,
	// fix_valid
	output logic        m_axis_tuser
);
	import cprgd_pkg::*;

	localparam int F   = ANGLE_FRAC_BITS;
	localparam int AW  = F + 9;     // magnitude of an angle below 360 degrees
	localparam int LW  = F + 10;    // signed angle
	localparam int NW2 = 12;        // longitude zone index, made non-negative
	localparam int NW3 = F + 16;    // longitude numerator
	localparam int PW2 = LW + 1 + CPR_W + 6;
	localparam int PW3 = LW + 1;

	localparam logic signed [LW-1:0] DEG90  = LW'(90) << F;
	localparam logic signed [LW-1:0] DEG180 = LW'(180) << F;
	localparam logic signed [LW-1:0] DEG270 = LW'(270) << F;
	localparam logic signed [LW-1:0] DEG360 = LW'(360) << F;
	localparam logic [25:0] ROUND_OFS = 26'd7929856;   // half zone plus 60 zones
	// ceil(2^35/59): exact floor(y/59) for y below 2^29
	localparam logic [29:0] RECIP59_HI = 30'd582368447;
	// ceil(2^26/59): exact floor(n/59) for the small tail numerator
	localparam logic [20:0] RECIP59_LO = 21'd1137439;

	function automatic logic [5:0] nl_of(input logic [AW-1:0] a);
		logic [5:0] cnt;
		cnt = '0;
		for (int i = 0; i < NL_EDGES; i++) begin
			if (a >= AW'(nl_thr(i, F))) begin
				cnt = 6'(i + 1);
			end
		end
		return 6'd59 - cnt;
	endfunction

	// ---- stage 1: latitude zone index ----
	logic              v_s1, rdy_s1;
	logic [CPR_W-1:0]  le_s1, ln_s1, lo_s1, lno_s1;
	logic              odd_s1;
	logic [6:0]        k_s1;          // j + 60
	logic [25:0]       t1;

	// ---- stage 2: even latitude, odd latitude scaled by 45 ----
	logic              v_s2, rdy_s2;
	logic [AW-1:0]     late_s2;
	logic [28:0]       y_s2;
	logic [CPR_W-1:0]  ln_s2, lno_s2;
	logic              odd_s2;
	logic [5:0]        je, jo;
	logic [7:0]        jx;

	// ---- stage 3: reciprocal product for the coarse divide by 59 ----
	logic              v_s3, rdy_s3;
	logic [58:0]       prod_s3;
	logic [28:0]       y_s3;
	logic [AW-1:0]     late_s3;
	logic [CPR_W-1:0]  ln_s3, lno_s3;
	logic              odd_s3;

	// ---- stage 4: coarse quotient, tail numerator ----
	logic              v_s4, rdy_s4;
	logic [23:0]       q_s4;
	logic [19:0]       n2_s4;
	logic [AW-1:0]     late_s4;
	logic [CPR_W-1:0]  ln_s4, lno_s4;
	logic              odd_s4;
	logic [23:0]       quo_c;
	logic [28:0]       rem_c;

	// ---- stage 5: reciprocal product for the tail ----
	logic              v_s5, rdy_s5;
	logic [40:0]       prod2_s5;
	logic [23:0]       q_s5;
	logic [AW-1:0]     late_s5;
	logic [CPR_W-1:0]  ln_s5, lno_s5;
	logic              odd_s5;
	logic [AW-1:0]     lato_c;

	// ---- stage 6: southern wrap and magnitudes ----
	logic              v_s6, rdy_s6;
	logic signed [LW-1:0] late_s6, lato_s6;
	logic [AW-1:0]     abse_s6, abso_s6;
	logic [CPR_W-1:0]  ln_s6, lno_s6;
	logic              odd_s6;

	// ---- stage 7: NL match and pole check ----
	logic              v_s7, rdy_s7;
	logic signed [LW-1:0] lat_s7;
	logic              fix_s7;
	logic [5:0]        nl_s7;
	logic [CPR_W-1:0]  ln_s7, lno_s7;
	logic              odd_s7;
	logic [5:0]        nl_e, nl_o;
	logic signed [LW-1:0] lat_sel;

	// ---- stage 8: longitude zone index ----
	logic              v_s8, rdy_s8;
	logic [NW2-1:0]    u_s8;
	logic [5:0]        ni_s8;
	logic signed [LW-1:0] lat_s8;
	logic              fix_s8;
	logic [CPR_W-1:0]  lsel_s8;
	logic [25:0]       t8;
	logic [5:0]        ni_c;

	// ---- divider 2: zone index mod ni ----
	logic              d2_in_ready, d2_out_valid;
	logic [NW2-1:0]    d2_quot;
	logic [5:0]        d2_rem;
	logic [PW2-1:0]    d2_pay;

	// ---- stage 9: longitude numerator ----
	logic              v_s9, rdy_s9;
	logic [NW3-1:0]    lonn_s9;
	logic [6:0]        den_s9;
	logic signed [LW-1:0] lat_s9;
	logic              fix_s9;
	logic [NW3-2:0]    num9;

	// ---- divider 3: longitude / (2 ni) ----
	logic              d3_in_ready, d3_out_valid;
	logic [NW3-1:0]    d3_quot;
	logic [6:0]        d3_rem;
	logic [PW3-1:0]    d3_pay;
	logic [AW-1:0]     d3_lon;

	// ---- stage 10: output register ----
	logic              v_s10, rdy_s10;
	logic signed [LW-1:0] lat_s10, lon_s10;
	logic              fix_s10;
	logic signed [63:0] lat_x, lon_x;

	// ready ripples back from the output register
	assign rdy_s10 = !v_s10 || m_axis_tready;
	assign rdy_s9  = !v_s9 || d3_in_ready;
	assign rdy_s8  = !v_s8 || d2_in_ready;
	assign rdy_s7  = !v_s7 || rdy_s8;
	assign rdy_s6  = !v_s6 || rdy_s7;
	assign rdy_s5  = !v_s5 || rdy_s6;
	assign rdy_s4  = !v_s4 || rdy_s5;
	assign rdy_s3  = !v_s3 || rdy_s4;
	assign rdy_s2  = !v_s2 || rdy_s3;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	// j = floor((59*le - 60*lo + half zone) / zone), offset by 60 zones
	assign t1 = 26'(s_axis_tdata[16:0]) * 26'd59 + ROUND_OFS
		- 26'(s_axis_tdata[50:34]) * 26'd60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			le_s1  <= s_axis_tdata[16:0];
			ln_s1  <= s_axis_tdata[33:17];
			lo_s1  <= s_axis_tdata[50:34];
			lno_s1 <= s_axis_tdata[67:51];
			odd_s1 <= s_axis_tuser;
			k_s1   <= t1[23:17];
		end
	end

	// zone indices mod 60 and mod 59
	always_comb begin
		je = (k_s1 >= 7'd60) ? 6'(k_s1 - 7'd60) : 6'(k_s1);
		jx = 8'(k_s1) + 8'd58;
		if (jx >= 8'd177) begin
			jo = 6'(jx - 8'd177);
		end else if (jx >= 8'd118) begin
			jo = 6'(jx - 8'd118);
		end else if (jx >= 8'd59) begin
			jo = 6'(jx - 8'd59);
		end else begin
			jo = 6'(jx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			late_s2 <= AW'(25'({je, le_s1}) * 25'd3) << (F - 16);
			y_s2    <= 29'({jo, lo_s1}) * 29'd45;
			ln_s2   <= ln_s1;
			lno_s2  <= lno_s1;
			odd_s2  <= odd_s1;
		end
	end

	// odd latitude = (y * 2^(F-14) + 29) / 59, split as y = 59 q + r:
	// q * 2^(F-14) + (r * 2^(F-14) + 29) / 59
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			prod_s3 <= 59'(y_s2) * 59'(RECIP59_HI);
			y_s3    <= y_s2;
			late_s3 <= late_s2;
			ln_s3   <= ln_s2;
			lno_s3  <= lno_s2;
			odd_s3  <= odd_s2;
		end
	end

	assign quo_c = prod_s3[58:35];
	assign rem_c = y_s3 - 29'(30'(quo_c) * 30'd59);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			q_s4    <= quo_c;
			n2_s4   <= (20'(rem_c[5:0]) << (F - 14)) + 20'd29;
			late_s4 <= late_s3;
			ln_s4   <= ln_s3;
			lno_s4  <= lno_s3;
			odd_s4  <= odd_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			prod2_s5 <= 41'(n2_s4) * 41'(RECIP59_LO);
			q_s5     <= q_s4;
			late_s5  <= late_s4;
			ln_s5    <= ln_s4;
			lno_s5   <= lno_s4;
			odd_s5   <= odd_s4;
		end
	end

	assign lato_c = (AW'(q_s5) << (F - 14)) + AW'(prod2_s5[40:26]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	// wrap southern latitudes: 270 degrees and up become negative
	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			if ({1'b0, late_s5} >= DEG270) begin
				late_s6 <= $signed({1'b0, late_s5}) - DEG360;
				abse_s6 <= DEG360[AW-1:0] - late_s5;
			end else begin
				late_s6 <= $signed({1'b0, late_s5});
				abse_s6 <= late_s5;
			end
			if ({1'b0, lato_c} >= DEG270) begin
				lato_s6 <= $signed({1'b0, lato_c}) - DEG360;
				abso_s6 <= DEG360[AW-1:0] - lato_c;
			end else begin
				lato_s6 <= $signed({1'b0, lato_c});
				abso_s6 <= lato_c;
			end
			ln_s6  <= ln_s5;
			lno_s6 <= lno_s5;
			odd_s6 <= odd_s5;
		end
	end

	assign nl_e    = nl_of(abse_s6);
	assign nl_o    = nl_of(abso_s6);
	assign lat_sel = odd_s6 ? lato_s6 : late_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (rdy_s7) begin
			v_s7 <= v_s6;
		end
	end

	// drop the pair on NL mismatch or a newer latitude beyond the poles
	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			lat_s7 <= lat_sel;
			fix_s7 <= (nl_e == nl_o) && (lat_sel >= -DEG90) && (lat_sel <= DEG90);
			nl_s7  <= odd_s6 ? nl_o : nl_e;
			ln_s7  <= ln_s6;
			lno_s7 <= lno_s6;
			odd_s7 <= odd_s6;
		end
	end

	// m + 60 = floor((ln*(nl-1) - lno*nl + half zone) / zone) + 60
	assign t8 = 26'(ln_s7) * 26'(nl_s7 - 6'd1) + ROUND_OFS - 26'(lno_s7) * 26'(nl_s7);
	always_comb begin
		ni_c = nl_s7 - 6'(odd_s7);
		if (ni_c == 6'd0) begin
			ni_c = 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (rdy_s8) begin
			v_s8 <= v_s7;
		end
	end

	// add 60 zones of ni so the index stays non-negative for the modulo
	always_ff @(posedge clk) begin
		if (rdy_s8 && v_s7) begin
			u_s8    <= NW2'(t8[23:17]) + NW2'(ni_c - 6'd1) * NW2'(60);
			ni_s8   <= ni_c;
			lat_s8  <= lat_s7;
			fix_s8  <= fix_s7;
			lsel_s8 <= odd_s7 ? lno_s7 : ln_s7;
		end
	end

	cprgd_div_pipe #(
		.NW(NW2),
		.DW(6),
		.PW(PW2),
		.BPS(DIV_BPS)
	) u_div_zone (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_ready  (d2_in_ready),
		.in_num    (u_s8),
		.in_den    (ni_s8),
		.in_pay    ({ni_s8, lsel_s8, fix_s8, lat_s8}),
		.out_valid (d2_out_valid),
		.out_ready (rdy_s9),
		.out_quot  (d2_quot),
		.out_rem   (d2_rem),
		.out_pay   (d2_pay)
	);

	assign num9 = (NW3-1)'(29'({d2_rem, d2_pay[LW + 1 +: CPR_W]}) * 29'd45) << (F - 14);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (rdy_s9) begin
			v_s9 <= d2_out_valid;
		end
	end

	// round to nearest: (2*num + ni) / (2*ni)
	always_ff @(posedge clk) begin
		if (rdy_s9 && d2_out_valid) begin
			lonn_s9 <= {num9, 1'b0} + NW3'(d2_pay[PW2-1 -: 6]);
			den_s9  <= {d2_pay[PW2-1 -: 6], 1'b0};
			lat_s9  <= d2_pay[LW-1:0];
			fix_s9  <= d2_pay[LW];
		end
	end

	cprgd_div_pipe #(
		.NW(NW3),
		.DW(7),
		.PW(PW3),
		.BPS(DIV_BPS)
	) u_div_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s9),
		.in_ready  (d3_in_ready),
		.in_num    (lonn_s9),
		.in_den    (den_s9),
		.in_pay    ({fix_s9, lat_s9}),
		.out_valid (d3_out_valid),
		.out_ready (rdy_s10),
		.out_quot  (d3_quot),
		.out_rem   (d3_rem),
		.out_pay   (d3_pay)
	);

	assign d3_lon = d3_quot[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (rdy_s10) begin
			v_s10 <= d3_out_valid;
		end
	end

	// fold longitude into [-180, 180); zero both angles on a rejected pair
	always_ff @(posedge clk) begin
		if (rdy_s10 && d3_out_valid) begin
			fix_s10 <= d3_pay[LW];
			if (d3_pay[LW]) begin
				lat_s10 <= d3_pay[LW-1:0];
				if ({1'b0, d3_lon} >= DEG180) begin
					lon_s10 <= $signed({1'b0, d3_lon}) - DEG360;
				end else begin
					lon_s10 <= $signed({1'b0, d3_lon});
				end
			end else begin
				lat_s10 <= '0;
				lon_s10 <= '0;
			end
		end
	end

	assign lat_x = 64'(lat_s10);
	assign lon_x = 64'(lon_s10);

	assign m_axis_tvalid = v_s10;
	assign m_axis_tuser  = fix_s10;
	assign m_axis_tdata  = {7'b0, lon_x[32:0], lat_x[31:0]};

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && !fix_s10 |-> lat_s10 == '0 && lon_s10 == '0)
		else $error("rejected pair with non-zero angles");
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && fix_s10 |-> lat_s10 >= -DEG90 && lat_s10 <= DEG90)
		else $error("decoded latitude beyond the poles");
	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && fix_s10 |-> lon_s10 >= -DEG180 && lon_s10 < DEG180)
		else $error("longitude not folded");

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = cprgd_pkg::ANGLE_FRAC_BITS_DEF;
	localparam int LATENCY = 17;

	typedef struct packed {
		logic [16:0] even_lat;
		logic [16:0] even_lon;
		logic [16:0] odd_lat;
		logic [16:0] odd_lon;
		logic        newer_odd;
	} pair_t;

	typedef struct packed {
		logic        fix;
		logic [31:0] lat;
		logic [32:0] lon;
	} fix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        m_axis_tuser;

	pair_t pending_pairs[$];
	fix_t  expected_fixes[$];
	int    mismatches = 0;
	bit    stim_done = 1'b0;
	bit    calm = 1'b0;

	cpr_global_position_decode_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// NL zone count of a Q.FB latitude
	function automatic longint zones_at(longint lat_q);
		longint a;
		longint nl;
		a = lat_q < 0 ? -lat_q : lat_q;
		nl = 59;
		for (int i = 0; i < 58; i++) begin
			if (a * 64'd100000000 < (longint'(cprgd_pkg::NL_EDGE[i]) << FB))
				break;
			nl--;
		end
		return nl;
	endfunction

	// floor((v + half zone) / zone), valid for the operand ranges seen here
	function automatic longint nearest_zone(longint v);
		longint t;
		t = v + 65536 + 60 * 131072;
		return (t >>> 17) - 60;
	endfunction

	function automatic fix_t decode_pair(pair_t p);
		fix_t r;
		longint j, je, jo, lat_e, lat_o, lat, nl, m, ni, mm, lon, lcpr;
		longint unsigned num;
		r = '0;
		j = nearest_zone(59 * longint'(p.even_lat) - 60 * longint'(p.odd_lat));
		je = (j + 120) % 60;
		jo = (j + 118) % 59;
		lat_e = (3 * (je * 131072 + p.even_lat)) <<< (FB - 16);
		num = (64'd45 * longint'(jo * 131072 + p.odd_lat)) << (FB - 14);
		lat_o = longint'((num + 29) / 59);
		if (lat_e >= (longint'(270) <<< FB)) lat_e -= longint'(360) <<< FB;
		if (lat_o >= (longint'(270) <<< FB)) lat_o -= longint'(360) <<< FB;
		if (zones_at(lat_e) != zones_at(lat_o)) return r;
		lat = p.newer_odd ? lat_o : lat_e;
		if (lat < -(longint'(90) <<< FB) || lat > (longint'(90) <<< FB)) return r;
		nl = zones_at(lat);
		m = nearest_zone(longint'(p.even_lon) * (nl - 1) - longint'(p.odd_lon) * nl);
		ni = nl - (p.newer_odd ? 1 : 0);
		if (ni < 1) ni = 1;
		mm = ((m % ni) + ni) % ni;
		lcpr = p.newer_odd ? p.odd_lon : p.even_lon;
		num = (64'd45 * longint'(mm * 131072 + lcpr)) << (FB - 14);
		lon = longint'((2 * num + ni) / (2 * ni));
		if (lon >= (longint'(180) <<< FB)) lon -= longint'(360) <<< FB;
		r.fix = 1'b1;
		r.lat = lat[31:0];
		r.lon = lon[32:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// driver: hold the word until accepted, idle at random outside calm stretches
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
					pair_t p;
					p = pending_pairs.pop_front();
					expected_fixes.push_back(decode_pair(p));
					s_axis_tdata <= {4'b0, p.odd_lon, p.odd_lat, p.even_lon, p.even_lat};
					s_axis_tuser <= p.newer_odd;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted word with the oldest expected fix
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_fixes.size() == 0) begin
					report_mismatch("unexpected word", 0, 0);
				end else begin
					fix_t want;
					want = expected_fixes.pop_front();
					if (m_axis_tuser !== want.fix)
						report_mismatch("fix_valid", m_axis_tuser, want.fix);
					if (m_axis_tdata[31:0] !== want.lat)
						report_mismatch("lat_deg", $signed(m_axis_tdata[31:0]),
							$signed(want.lat));
					if (m_axis_tdata[64:32] !== want.lon)
						report_mismatch("lon_deg", $signed(m_axis_tdata[64:32]),
							$signed(want.lon));
					if (m_axis_tdata[71:65] !== 7'b0)
						report_mismatch("tdata fill", m_axis_tdata[71:65], 0);
				end
			end
			m_axis_tready <= calm || $urandom_range(99) >= 12;
		end
	end

	function automatic pair_t random_pair();
		pair_t p;
		p.even_lat = $urandom_range(131071);
		p.even_lon = $urandom_range(131071);
		p.odd_lat = $urandom_range(131071);
		p.odd_lon = $urandom_range(131071);
		p.newer_odd = $urandom_range(1);
		return p;
	endfunction

	// derive the odd latitude from the even one so that most pairs decode
	function automatic pair_t consistent_pair();
		pair_t p;
		longint o;
		p = random_pair();
		o = (longint'(p.even_lat) * 59 / 60 + $urandom_range(40) - 20);
		if (o < 0) o = 0;
		if (o > 131071) o = 131071;
		p.odd_lat = o[16:0];
		return p;
	endfunction

	initial begin
		pair_t p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, both newer frames, poles, wraps, polar zones
		for (int k = 0; k < 2; k++) begin
			pending_pairs.push_back('{17'd0, 17'd0, 17'd0, 17'd0, k[0]});
			pending_pairs.push_back('{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, k[0]});
			pending_pairs.push_back('{17'h1FFFF, 17'd0, 17'd0, 17'h1FFFF, k[0]});
			pending_pairs.push_back('{17'd0, 17'h1FFFF, 17'h1FFFF, 17'd0, k[0]});
			pending_pairs.push_back('{17'd65536, 17'd65536, 17'd64444, 17'd1, k[0]});
			pending_pairs.push_back('{17'd130000, 17'd12345, 17'd127800, 17'd54321, k[0]});
			pending_pairs.push_back('{17'd131000, 17'd99, 17'd131071, 17'd7, k[0]});
			pending_pairs.push_back('{17'd1000, 17'd70000, 17'd990, 17'd65000, k[0]});
			pending_pairs.push_back('{17'd87381, 17'd3, 17'd85900, 17'd131070, k[0]});
			pending_pairs.push_back('{17'd43690, 17'd131071, 17'd43000, 17'd2, k[0]});
			pending_pairs.push_back('{17'd20000, 17'd500, 17'd90000, 17'd600, k[0]});
		end

		// random: mostly consistent pairs, the rest unrelated noise
		for (int n = 0; n < 1950; n++) begin
			if (n == 600) calm = 1'b1;
			if (n == 900) calm = 1'b0;
			p = ($urandom_range(99) < 70) ? consistent_pair() : random_pair();
			pending_pairs.push_back(p);
			while (pending_pairs.size() > 16) @(posedge clk);
		end
		while (pending_pairs.size() > 0 || s_axis_tvalid) @(posedge clk);
		while (expected_fixes.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_fixes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// generous watchdog: ~2000 words, with ample time even when stalled
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
